>>> src/tptt_pkg.sv
// Package for the three-level priority ticket table.
// Holds the codes, payload structs and cell control struct; no dependencies.
package tptt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_BITS_DEF  = 16;
    localparam int IN_ID_W      = 16;

    typedef enum logic [1:0] {
        FUNC_REGISTER = 2'd0,
        FUNC_REPRI    = 2'd1,
        FUNC_SERVE    = 2'd2,
        FUNC_LOOKUP   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_BADLEVEL = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    localparam logic [1:0] LVL_LOW     = 2'd0;
    localparam logic [1:0] LVL_MED     = 2'd1;
    localparam logic [1:0] LVL_HIGH    = 2'd2;
    localparam logic [1:0] LVL_INVALID = 2'd3;

    typedef struct packed {
        t_func              func;
        logic [IN_ID_W-1:0] ticket_id;
        logic [1:0]         new_level;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [IN_ID_W-1:0] result_id;
        logic [1:0]         result_level;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EVAL  = 2'd1,
        S_APPLY = 2'd2
    } t_state;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic       eval;
        logic       do_reg;
        logic       do_repri;
        logic       do_serve;
        logic       rd_hit;
        logic [1:0] level;
    } t_cell_ctl;

endpackage

>>> src/tptt_cell.sv
// One slot of the ticket chain: occupied flag, ID, level and the search hit.
// Depends on tptt_pkg.
module tptt_cell #(
    parameter int ID_BITS = tptt_pkg::ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tptt_pkg::t_cell_ctl  i_ctl,
    input  logic [ID_BITS-1:0]   i_id,
    input  logic                 i_prev_occ,
    input  logic                 i_next_occ,
    input  logic [ID_BITS-1:0]   i_next_id,
    input  logic [1:0]           i_next_level,
    input  logic                 i_found,
    output logic                 o_found,
    output logic                 o_occ,
    output logic [ID_BITS-1:0]   o_id,
    output logic [1:0]           o_level,
    output logic                 o_match,
    output logic                 o_is_high,
    output logic                 o_is_med,
    output logic [ID_BITS-1:0]   o_rd_id,
    output logic [1:0]           o_rd_level
);
    import tptt_pkg::*;

    logic               r_occ, n_occ;
    logic               r_hit, n_hit;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [1:0]         r_level, n_level;
    logic               w_tgt, w_first, w_sel;

    assign o_match   = r_occ && (r_id == i_id);
    assign o_is_high = r_occ && (r_level == LVL_HIGH);
    assign o_is_med  = r_occ && (r_level == LVL_MED);

    // serve: oldest cell at the target level is removed, everything after closes up
    assign w_tgt   = r_occ && (r_level == i_ctl.level);
    assign w_first = w_tgt && !i_found;
    assign o_found = i_found || w_tgt;

    assign w_sel      = (i_ctl.rd_hit && r_hit) || (i_ctl.do_serve && w_first);
    assign o_rd_id    = w_sel ? r_id : '0;
    assign o_rd_level = w_sel ? r_level : LVL_LOW;

    assign o_occ   = r_occ;
    assign o_id    = r_id;
    assign o_level = r_level;

    always_comb begin
        n_occ   = r_occ;
        n_id    = r_id;
        n_level = r_level;
        n_hit   = r_hit;
        if (i_ctl.eval) begin
            n_hit = o_match;
        end
        if (i_ctl.do_reg && !r_occ && i_prev_occ) begin
            n_occ   = 1'b1;
            n_id    = i_id;
            n_level = LVL_LOW;
        end
        if (i_ctl.do_repri && r_hit) begin
            n_level = i_ctl.level;
        end
        if (i_ctl.do_serve && o_found) begin
            n_occ   = i_next_occ;
            n_id    = i_next_id;
            n_level = i_next_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_occ <= n_occ;
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_level <= n_level;
    end

endmodule

>>> src/three_level_priority_ticket_table.sv
// Top level of the three-level priority ticket table: sequencer, output register
// and the chain of tptt_cell slots. Depends on tptt_pkg and tptt_cell.
//
//   channel | direction | handshake              | payload
//   in      | input     | i_in_valid / o_in_ready | i_in_data  (t_in)
//   out     | output    | o_out_valid / i_out_ready | o_out_data (t_out)
//
// Each transfer passes through S_EVAL, for the parallel ID compare and level scan
// across the cells, and then S_APPLY, for the decision, the update of the chain
// (write, level change or compacting shift) and loading the output register.
// The next transfer is taken in the update cycle when the output register is free.
// A stalled output holds the block in the update cycle; nothing changes until it drains.
// Synchronous active-low reset empties the table; IDs and levels are not cleared.
module three_level_priority_ticket_table #(
    parameter int CAPACITY = tptt_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = tptt_pkg::ID_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tptt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tptt_pkg::t_out o_out_data
);
    import tptt_pkg::*;

    localparam logic [IN_ID_W-1:0] ID_MASK = (ID_BITS >= IN_ID_W) ? {IN_ID_W{1'b1}} :
                                             IN_ID_W'((64'd1 << ID_BITS) - 64'd1);

    t_state    r_state, n_state;
    t_in       r_op;
    t_out      r_out, n_out;
    logic      r_out_valid;
    logic      r_any_hit, r_any_high, r_any_med;
    logic      w_accept, w_load;
    t_cell_ctl w_ctl;

    logic [ID_BITS-1:0] w_op_id;

    logic [CAPACITY-1:0] w_occ, w_match, w_high, w_med;
    logic [CAPACITY:0]   w_found;
    logic [ID_BITS-1:0]  w_cid [CAPACITY];
    logic [1:0]          w_clvl [CAPACITY];
    logic [ID_BITS-1:0]  w_rid [CAPACITY];
    logic [1:0]          w_rlvl [CAPACITY];
    logic [ID_BITS-1:0]  w_rd_id;
    logic [1:0]          w_rd_level;
    logic                w_full, w_empty;

    assign w_op_id = ID_BITS'(r_op.ticket_id & ID_MASK);
    assign w_found[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic               w_prev_occ, w_next_occ;
            logic [ID_BITS-1:0] w_next_id;
            logic [1:0]         w_next_level;
            if (g == 0) begin : g_first
                assign w_prev_occ = 1'b1;
            end else begin : g_mid
                assign w_prev_occ = w_occ[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_next_occ   = 1'b0;
                assign w_next_id    = '0;
                assign w_next_level = LVL_LOW;
            end else begin : g_inner
                assign w_next_occ   = w_occ[g+1];
                assign w_next_id    = w_cid[g+1];
                assign w_next_level = w_clvl[g+1];
            end
            tptt_cell #(.ID_BITS(ID_BITS)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_id         (w_op_id),
                .i_prev_occ   (w_prev_occ),
                .i_next_occ   (w_next_occ),
                .i_next_id    (w_next_id),
                .i_next_level (w_next_level),
                .i_found      (w_found[g]),
                .o_found      (w_found[g+1]),
                .o_occ        (w_occ[g]),
                .o_id         (w_cid[g]),
                .o_level      (w_clvl[g]),
                .o_match      (w_match[g]),
                .o_is_high    (w_high[g]),
                .o_is_med     (w_med[g]),
                .o_rd_id      (w_rid[g]),
                .o_rd_level   (w_rlvl[g])
            );
        end
    endgenerate

    // at most one cell drives a non-zero read value
    always_comb begin
        w_rd_id    = '0;
        w_rd_level = LVL_LOW;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_id    = w_rd_id | w_rid[i];
            w_rd_level = w_rd_level | w_rlvl[i];
        end
    end

    assign w_full  = w_occ[CAPACITY-1];
    assign w_empty = !w_occ[0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = i_in_valid ? S_EVAL : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_EVAL: begin
                o_in_ready = 1'b0;
            end
            S_APPLY: begin
                w_load     = !r_out_valid || i_out_ready;
                o_in_ready = w_load;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // decision for the item in hand
    always_comb begin
        w_ctl          = '0;
        w_ctl.eval     = (r_state == S_EVAL);
        n_out.status       = ST_OK;
        n_out.result_id    = IN_ID_W'(w_rd_id);
        n_out.result_level = w_rd_level;
        case (r_op.func)
            FUNC_REGISTER: begin
                if (r_any_hit) begin
                    n_out.status = ST_DUP;
                end else if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_ctl.do_reg = w_load;
                end
            end
            FUNC_REPRI: begin
                w_ctl.level = r_op.new_level;
                if (r_op.new_level == LVL_INVALID) begin
                    n_out.status = ST_BADLEVEL;
                end else if (!r_any_hit) begin
                    n_out.status = ST_NOTFOUND;
                end else begin
                    w_ctl.do_repri = w_load;
                end
            end
            FUNC_SERVE: begin
                w_ctl.level = r_any_high ? LVL_HIGH : (r_any_med ? LVL_MED : LVL_LOW);
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    w_ctl.do_serve = w_load;
                end
            end
            FUNC_LOOKUP: begin
                if (!r_any_hit) begin
                    n_out.status = ST_NOTFOUND;
                end else begin
                    w_ctl.rd_hit = 1'b1;
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
        // the read path only selects on serve or lookup
        if (!w_ctl.do_serve && !w_ctl.rd_hit) begin
            n_out.result_id    = '0;
            n_out.result_level = LVL_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_in_data;
        end
        if (r_state == S_EVAL) begin
            r_any_hit  <= |w_match;
            r_any_high <= |w_high;
            r_any_med  <= |w_med;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_occ_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ >> 1) & ~w_occ) == '0)
        else $error("occupied cells not contiguous from cell zero");

    a_accept_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_state == S_IDLE || w_load))
        else $error("transfer taken while an item is in evaluation");

    a_serve_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.do_serve |=> $countones(w_occ) == $past($countones(w_occ)) - 1)
        else $error("serve did not remove exactly one ticket");

    a_reg_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.do_reg |=> $countones(w_occ) == $past($countones(w_occ)) + 1)
        else $error("register did not add exactly one ticket");
`endif

endmodule
